FILE: hw/rtl/dsu_pkg.sv
// Shared types and codes for the disjoint-set union/find block.
// No dependencies; used by the controller, output stage and top level.
package dsu_pkg;

  localparam int NODES_DEF = 64;

  localparam int NODE_FW = 6;
  localparam int SIZE_FW = 7;

  localparam logic [1:0] OP_MAKE  = 2'd0;
  localparam logic [1:0] OP_FIND  = 2'd1;
  localparam logic [1:0] OP_UNION = 2'd2;

  typedef struct packed {
    logic [NODE_FW-1:0] rep;
    logic [SIZE_FW-1:0] size;
    logic               err;
  } res_t;

endpackage

FILE: hw/rtl/disjoint_set_union_find_top.sv
// Top level of the disjoint-set union/find block: controller, two tables,
// result register. Depends on dsu_pkg, dsu_mem, dsu_ctrl and dsu_out.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------
//   request  | req_valid / req_ready | opcode, node_a, node_b
//   result   | res_valid / res_ready | representative, set_size, error
//
// One request at a time. After acceptance, create and errors pass the states
// RDN and EMIT; find and a union within one set pass RDN, RDH and EMIT; a
// union of two sets also walks the smaller set (up to NODES/2 members) in
// WALK, one member at a time, set by the single write port of the node table.
// After reset a clearing pass runs over every entry of the node table;
// req_ready stays low meanwhile. A request is taken while a result still
// waits; a stalled result holds the next one in the controller.
module disjoint_set_union_find_top #(
  parameter int NODES = dsu_pkg::NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [1:0]                  opcode,
  input  logic [dsu_pkg::NODE_FW-1:0] node_a,
  input  logic [dsu_pkg::NODE_FW-1:0] node_b,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [dsu_pkg::NODE_FW-1:0] representative,
  output logic [dsu_pkg::SIZE_FW-1:0] set_size,
  output logic                        error
);

  localparam int IW = $clog2(NODES);
  localparam int SW = $clog2(NODES + 1);

  logic                node_we, head_we;
  logic [IW-1:0]       node_waddr, node_raddr0, node_raddr1;
  logic [IW-1:0]       head_waddr, head_raddr0, head_raddr1;
  logic [2*IW+1:0]     node_wdata, node_rdata0, node_rdata1;
  logic [IW+SW-1:0]    head_wdata, head_rdata0, head_rdata1;
  logic                res_load, res_busy;
  dsu_pkg::res_t       res;

  dsu_mem #(.WIDTH(2 * IW + 2), .DEPTH(NODES)) u_node_mem (
    .clk    (clk),
    .we     (node_we),
    .waddr  (node_waddr),
    .wdata  (node_wdata),
    .raddr0 (node_raddr0),
    .raddr1 (node_raddr1),
    .rdata0 (node_rdata0),
    .rdata1 (node_rdata1)
  );

  dsu_mem #(.WIDTH(IW + SW), .DEPTH(NODES)) u_head_mem (
    .clk    (clk),
    .we     (head_we),
    .waddr  (head_waddr),
    .wdata  (head_wdata),
    .raddr0 (head_raddr0),
    .raddr1 (head_raddr1),
    .rdata0 (head_rdata0),
    .rdata1 (head_rdata1)
  );

  dsu_ctrl #(.NODES(NODES), .IW(IW), .SW(SW)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .opcode      (opcode),
    .node_a      (node_a),
    .node_b      (node_b),
    .node_we     (node_we),
    .node_waddr  (node_waddr),
    .node_wdata  (node_wdata),
    .node_raddr0 (node_raddr0),
    .node_raddr1 (node_raddr1),
    .node_rdata0 (node_rdata0),
    .node_rdata1 (node_rdata1),
    .head_we     (head_we),
    .head_waddr  (head_waddr),
    .head_wdata  (head_wdata),
    .head_raddr0 (head_raddr0),
    .head_raddr1 (head_raddr1),
    .head_rdata0 (head_rdata0),
    .head_rdata1 (head_rdata1),
    .res_load    (res_load),
    .res         (res),
    .res_busy    (res_busy)
  );

  dsu_out u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (res_load),
    .res_in         (res),
    .busy           (res_busy),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .representative (representative),
    .set_size       (set_size),
    .error          (error)
  );

endmodule

FILE: hw/rtl/dsu_mem.sv
// Synchronous RAM, one write port and two read ports with registered data.
// Standalone; instantiated twice by the top level (node table, head table).
module dsu_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

FILE: hw/rtl/dsu_out.sv
// Result register between the controller and the result channel.
// Depends on dsu_pkg for the result struct.
module dsu_out (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  dsu_pkg::res_t                     res_in,
  output logic                              busy,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [dsu_pkg::NODE_FW-1:0]       representative,
  output logic [dsu_pkg::SIZE_FW-1:0]       set_size,
  output logic                              error
);

  dsu_pkg::res_t res_q;

  assign busy = res_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

  assign representative = res_q.rep;
  assign set_size       = res_q.size;
  assign error          = res_q.err;

endmodule

FILE: hw/rtl/dsu_ctrl.sv
// Sequencer for create / find / union over the node and head tables.
// Depends on dsu_pkg; drives the ports of two dsu_mem instances.
module dsu_ctrl #(
  parameter int NODES = dsu_pkg::NODES_DEF,
  parameter int IW    = $clog2(NODES),
  parameter int SW    = $clog2(NODES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [1:0]                  opcode,
  input  logic [dsu_pkg::NODE_FW-1:0] node_a,
  input  logic [dsu_pkg::NODE_FW-1:0] node_b,
  // node table: {valid, last, next, owner}
  output logic                        node_we,
  output logic [IW-1:0]               node_waddr,
  output logic [2*IW+1:0]             node_wdata,
  output logic [IW-1:0]               node_raddr0,
  output logic [IW-1:0]               node_raddr1,
  input  logic [2*IW+1:0]             node_rdata0,
  input  logic [2*IW+1:0]             node_rdata1,
  // head table: {tail, size}
  output logic                        head_we,
  output logic [IW-1:0]               head_waddr,
  output logic [IW+SW-1:0]            head_wdata,
  output logic [IW-1:0]               head_raddr0,
  output logic [IW-1:0]               head_raddr1,
  input  logic [IW+SW-1:0]            head_rdata0,
  input  logic [IW+SW-1:0]            head_rdata1,
  output logic                        res_load,
  output dsu_pkg::res_t               res,
  input  logic                        res_busy
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RDN   = 6'b000100,
    S_RDH   = 6'b001000,
    S_WALK  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [IW-1:0] clr_idx;
  logic [1:0]    op;
  logic [IW-1:0] a_idx;
  logic          a_inr, b_inr;
  logic [IW-1:0] h1, h2, z, big;
  dsu_pkg::res_t res_next;
  logic          res_upd;
  logic          h_upd, z_upd, big_upd;
  logic [IW-1:0] h1_next, h2_next, z_next, big_next;

  // node table fields of both read ports
  logic          na_valid, nb_valid, na_last;
  logic [IW-1:0] na_next, na_owner, nb_owner;
  logic [IW-1:0] hd1_tail, hd2_tail;
  logic [SW-1:0] hd1_size, hd2_size;

  // union operands after ordering by size
  logic          swap;
  logic [IW-1:0] big_c, small_c, big_tail, small_tail;
  logic [SW-1:0] sum;

  assign na_valid = node_rdata0[2*IW+1];
  assign na_last  = node_rdata0[2*IW];
  assign na_next  = node_rdata0[2*IW-1:IW];
  assign na_owner = node_rdata0[IW-1:0];
  assign nb_valid = node_rdata1[2*IW+1];
  assign nb_owner = node_rdata1[IW-1:0];

  assign hd1_tail = head_rdata0[IW+SW-1:SW];
  assign hd1_size = head_rdata0[SW-1:0];
  assign hd2_tail = head_rdata1[IW+SW-1:SW];
  assign hd2_size = head_rdata1[SW-1:0];

  // ties keep node_a's set as the head
  assign swap       = hd1_size < hd2_size;
  assign big_c      = swap ? h2 : h1;
  assign small_c    = swap ? h1 : h2;
  assign big_tail   = swap ? hd2_tail : hd1_tail;
  assign small_tail = swap ? hd1_tail : hd2_tail;
  assign sum        = hd1_size + hd2_size;

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    node_we     = 1'b0;
    node_waddr  = '0;
    node_wdata  = '0;
    node_raddr0 = '0;
    node_raddr1 = '0;
    head_we     = 1'b0;
    head_waddr  = '0;
    head_wdata  = '0;
    head_raddr0 = '0;
    head_raddr1 = '0;
    res_load    = 1'b0;
    res_upd     = 1'b0;
    res_next    = '{rep: '0, size: '0, err: 1'b1};
    h_upd       = 1'b0;
    h1_next     = na_owner;
    h2_next     = nb_owner;
    z_upd       = 1'b0;
    z_next      = na_next;
    big_upd     = 1'b0;
    big_next    = big_c;

    unique case (state)
      S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_idx;
        if (clr_idx == IW'(NODES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready   = 1'b1;
        node_raddr0 = IW'(node_a);
        node_raddr1 = IW'(node_b);
        if (req_valid) begin
          state_next = S_RDN;
        end
      end
      S_RDN: begin
        state_next = S_EMIT;
        res_upd    = 1'b1;
        case (op)
          dsu_pkg::OP_MAKE: begin
            if (a_inr && !na_valid) begin
              node_we    = 1'b1;
              node_waddr = a_idx;
              node_wdata = {1'b1, 1'b1, {IW{1'b0}}, a_idx};
              head_we    = 1'b1;
              head_waddr = a_idx;
              head_wdata = {a_idx, SW'(1)};
              res_next   = '{rep: dsu_pkg::NODE_FW'(a_idx), size: dsu_pkg::SIZE_FW'(1),
                             err: 1'b0};
            end
          end
          dsu_pkg::OP_FIND: begin
            if (a_inr && na_valid) begin
              head_raddr0 = na_owner;
              h_upd       = 1'b1;
              res_upd     = 1'b0;
              state_next  = S_RDH;
            end
          end
          dsu_pkg::OP_UNION: begin
            if (a_inr && na_valid && b_inr && nb_valid) begin
              head_raddr0 = na_owner;
              head_raddr1 = nb_owner;
              h_upd       = 1'b1;
              res_upd     = 1'b0;
              state_next  = S_RDH;
            end
          end
          default: ;
        endcase
      end
      S_RDH: begin
        res_upd = 1'b1;
        if (op == dsu_pkg::OP_FIND || h1 == h2) begin
          res_next   = '{rep: dsu_pkg::NODE_FW'(h1), size: dsu_pkg::SIZE_FW'(hd1_size),
                         err: 1'b0};
          state_next = S_EMIT;
        end else begin
          // link big tail to small head, then repoint the small list
          node_we     = 1'b1;
          node_waddr  = big_tail;
          node_wdata  = {1'b1, 1'b0, small_c, big_c};
          head_we     = 1'b1;
          head_waddr  = big_c;
          head_wdata  = {small_tail, sum};
          node_raddr0 = small_c;
          z_upd       = 1'b1;
          z_next      = small_c;
          big_upd     = 1'b1;
          res_next    = '{rep: dsu_pkg::NODE_FW'(big_c), size: dsu_pkg::SIZE_FW'(sum),
                          err: 1'b0};
          state_next  = S_WALK;
        end
      end
      S_WALK: begin
        node_we    = 1'b1;
        node_waddr = z;
        node_wdata = {1'b1, na_last, na_next, big};
        if (na_last) begin
          state_next = S_EMIT;
        end else begin
          node_raddr0 = na_next;
          z_upd       = 1'b1;
        end
      end
      S_EMIT: begin
        if (!res_busy) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      op    <= opcode;
      a_idx <= IW'(node_a);
      a_inr <= 32'(node_a) < NODES;
      b_inr <= 32'(node_b) < NODES;
    end
    if (h_upd) begin
      h1 <= h1_next;
      h2 <= h2_next;
    end
    if (z_upd) begin
      z <= z_next;
    end
    if (big_upd) begin
      big <= big_next;
    end
    if (res_upd) begin
      res <= res_next;
    end
  end

endmodule

FILE: hw/rtl/dsu_checker.sv
// Port-level checks for the disjoint-set union/find top level.
// Depends on dsu_pkg; bound to disjoint_set_union_find_top below.
module dsu_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [dsu_pkg::NODE_FW-1:0] representative,
  input logic [dsu_pkg::SIZE_FW-1:0] set_size,
  input logic                        error
);

  // hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(representative) &&
    $stable(set_size) && $stable(error))
    else $error("stalled result changed");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && error |-> representative == '0 && set_size == '0)
    else $error("error result with nonzero payload");

  a_ok_size: assert property (@(posedge clk) disable iff (rst)
    res_valid && !error |-> set_size != '0)
    else $error("good result with empty set");

  // one request in flight at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken on back-to-back cycles");

endmodule

bind disjoint_set_union_find_top dsu_checker u_dsu_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_ready      (req_ready),
  .res_valid      (res_valid),
  .res_ready      (res_ready),
  .representative (representative),
  .set_size       (set_size),
  .error          (error)
);
